@@ hdl/rfp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types and constants of the radio receive frame parser.
// ----------------------------------------------------------------------------
package rfp_pkg;

  // receive FIFO geometry
  localparam int FIFO_DEPTH = 128;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // input function codes
  localparam logic [1:0] FUNC_RX    = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  // framing constants
  localparam logic [7:0] SFD_BYTE       = 8'h7A;
  localparam logic [2:0] PREAMBLE_ZEROS = 3'd4;
  localparam logic [7:0] RSSI_BYTE      = 8'hCE;
  localparam logic [7:0] STATUS_BYTE    = 8'hB2;
  localparam logic [7:0] ACK_LEN_BYTE   = 8'd5;
  localparam logic [7:0] ACK_FCF_BYTE   = 8'h02;
  localparam logic [3:0] ACK_BEATS      = 4'd11;

  // ack beat positions carrying the SFD, length, FCF and sequence bytes
  localparam logic [3:0] BEAT_SFD = 4'd4;
  localparam logic [3:0] BEAT_LEN = 4'd5;
  localparam logic [3:0] BEAT_FCF = 4'd6;
  localparam logic [3:0] BEAT_SEQ = 4'd8;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       sfd_detected;
    logic       frame_done;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [7:0] fifo_count;
    logic       last;
  } out_t;

endpackage
`default_nettype wire

@@ hdl/rfp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hdl/radio_rx_frame_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radio_rx_frame_parser
// Byte-wise receive deframer feeding a receive FIFO, with optional auto-ACK.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per item: func selects received byte, FIFO read
//           or flush; rx_byte is the over-the-air byte.
//   out_* : one result per item, or eleven (ACK bytes) when a completed
//           frame requests an acknowledgment and autoack is enabled; the
//           final result of an item carries last.
//   cfg_* : one-bit autoack_enable write, always ready.
// Path: an accepted item goes to the pending slot, then to the output
//   register; the FIFO RAM read runs alongside the pending slot load.
// Throughput: one item per cycle while out_ready is high. A status-stamping
//   frame end holds off input while RSSI goes in (the RAM has one write
//   port), and an ACK item holds its result slot through all eleven beats.
// Stall: when out_ready is low, results wait in the output register and in
//   one pending slot; in_ready drops once both are occupied.
// Reset: synchronous; parser goes to preamble search and the FIFO is empty.
//   FIFO contents are not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module radio_rx_frame_parser (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire rfp_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output rfp_pkg::out_t     out_data,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_data
);

  import rfp_pkg::*;

  localparam logic [1:0] PH_PREAMBLE = 2'd0;
  localparam logic [1:0] PH_LENGTH   = 2'd1;
  localparam logic [1:0] PH_PAYLOAD  = 2'd2;

  typedef struct packed {
    logic       rd;
    logic       sfd;
    logic       done;
    logic       ack;
    logic [7:0] seq;
    logic [7:0] count;
  } desc_t;

  // parser and FIFO control registers
  logic               autoack_enable;
  logic [1:0]         phase, phase_next;
  logic [2:0]         zero_count, zero_count_next;
  logic [7:0]         frame_length, frame_length_next;
  logic [7:0]         payload_count, payload_count_next;
  logic               ack_requested, ack_requested_next;
  logic [7:0]         sequence_number, sequence_number_next;
  logic [FIFO_CW-1:0] fill, fill_next;
  logic [FIFO_CW-1:0] read_pos, read_pos_next;

  // deferred RSSI write
  logic               rssi_pend, rssi_pend_next;
  logic [FIFO_AW-1:0] rssi_addr, rssi_addr_next;

  // pending result descriptor and output stage
  logic               pend_valid;
  desc_t              pend, pend_next;
  logic [3:0]         beat;
  logic               out_load, beat_last, pend_done, accept;

  // RAM ports
  logic               ram_we, ram_re;
  logic [FIFO_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata;

  rfp_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;

  // handshake and result sequencing
  assign out_load  = pend_valid && (!out_valid || out_ready);
  assign beat_last = pend.ack ? (beat == ACK_BEATS - 4'd1) : 1'b1;
  assign pend_done = out_load && beat_last;
  assign in_ready  = !rssi_pend && (!pend_valid || pend_done);
  assign accept    = in_valid && in_ready;

  // step logic: parser, FIFO pointers and RAM access
  always_comb begin
    logic [FIFO_CW-1:0] fill_push;
    logic [7:0]         b;
    logic               push;
    logic               do_read;
    logic [FIFO_CW-1:0] rp_inc;

    phase_next           = phase;
    zero_count_next      = zero_count;
    frame_length_next    = frame_length;
    payload_count_next   = payload_count;
    ack_requested_next   = ack_requested;
    sequence_number_next = sequence_number;
    fill_next            = fill;
    read_pos_next        = read_pos;
    rssi_pend_next       = 1'b0;
    rssi_addr_next       = rssi_addr;
    pend_next            = '0;

    b         = in_data.rx_byte;
    push      = (fill < FIFO_CW'(FIFO_DEPTH));
    fill_push = fill + FIFO_CW'(push);
    do_read   = (read_pos < fill);
    rp_inc    = read_pos + FIFO_CW'(1);

    ram_we    = 1'b0;
    ram_waddr = fill[FIFO_AW-1:0];
    ram_wdata = b;
    ram_re    = 1'b0;
    ram_raddr = read_pos[FIFO_AW-1:0];

    if (rssi_pend) begin
      ram_we    = 1'b1;
      ram_waddr = rssi_addr;
      ram_wdata = RSSI_BYTE;
    end

    if (accept) begin
      case (in_data.func)
        FUNC_RX: begin
          case (phase)
            PH_LENGTH: begin
              frame_length_next  = b;
              payload_count_next = '0;
              ram_we             = push;
              fill_next          = fill_push;
              if (b == 8'd0) begin
                phase_next      = PH_PREAMBLE;
                zero_count_next = '0;
              end else begin
                phase_next = PH_PAYLOAD;
              end
            end
            PH_PAYLOAD: begin
              ram_we    = push;
              fill_next = fill_push;
              if (payload_count == 8'd0) begin
                ack_requested_next = b[5];
              end else if (payload_count == 8'd2) begin
                sequence_number_next = b;
              end
              payload_count_next = payload_count + 8'd1;
              if (payload_count_next >= frame_length) begin
                // stamp status now, RSSI on the next cycle
                if (fill_push >= FIFO_CW'(2)) begin
                  ram_we         = 1'b1;
                  ram_waddr      = FIFO_AW'(fill_push - FIFO_CW'(1));
                  ram_wdata      = STATUS_BYTE;
                  rssi_pend_next = 1'b1;
                  rssi_addr_next = FIFO_AW'(fill_push - FIFO_CW'(2));
                end
                pend_next.done  = 1'b1;
                pend_next.ack   = autoack_enable && ack_requested_next;
                phase_next      = PH_PREAMBLE;
                zero_count_next = '0;
              end
            end
            default: begin
              // preamble search
              if (b == 8'd0) begin
                if (zero_count < PREAMBLE_ZEROS) begin
                  zero_count_next = zero_count + 3'd1;
                end
              end else if (zero_count >= PREAMBLE_ZEROS && b == SFD_BYTE) begin
                pend_next.sfd = 1'b1;
                phase_next    = PH_LENGTH;
              end else begin
                zero_count_next = '0;
              end
            end
          endcase
        end
        FUNC_READ: begin
          if (do_read) begin
            ram_re       = 1'b1;
            pend_next.rd = 1'b1;
            if (rp_inc >= fill) begin
              read_pos_next = '0;
              fill_next     = '0;
            end else begin
              read_pos_next = rp_inc;
            end
          end
        end
        FUNC_FLUSH: begin
          fill_next       = '0;
          read_pos_next   = '0;
          phase_next      = PH_PREAMBLE;
          zero_count_next = '0;
        end
        default: begin
        end
      endcase
      pend_next.seq   = sequence_number_next;
      pend_next.count = 8'(fill_next - read_pos_next);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      autoack_enable  <= 1'b0;
      phase           <= PH_PREAMBLE;
      zero_count      <= '0;
      frame_length    <= '0;
      payload_count   <= '0;
      ack_requested   <= 1'b0;
      sequence_number <= '0;
      fill            <= '0;
      read_pos        <= '0;
      rssi_pend       <= 1'b0;
      pend_valid      <= 1'b0;
      beat            <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        autoack_enable <= cfg_data;
      end
      phase           <= phase_next;
      zero_count      <= zero_count_next;
      frame_length    <= frame_length_next;
      payload_count   <= payload_count_next;
      ack_requested   <= ack_requested_next;
      sequence_number <= sequence_number_next;
      fill            <= fill_next;
      read_pos        <= read_pos_next;
      rssi_pend       <= rssi_pend_next;

      if (accept) begin
        pend_valid <= 1'b1;
      end else if (pend_done) begin
        pend_valid <= 1'b0;
      end

      if (pend_done) begin
        beat <= '0;
      end else if (out_load) begin
        beat <= beat + 4'd1;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rssi_addr <= rssi_addr_next;
    if (accept) begin
      pend <= pend_next;
    end
    if (out_load) begin
      out_data.read_data    <= pend.rd ? ram_rdata : 8'd0;
      out_data.sfd_detected <= pend.sfd;
      out_data.frame_done   <= pend.done;
      out_data.tx_valid     <= pend.ack;
      out_data.fifo_count   <= pend.count;
      out_data.last         <= beat_last;
      out_data.tx_byte      <= 8'd0;
      if (pend.ack) begin
        case (beat)
          BEAT_SFD: out_data.tx_byte <= SFD_BYTE;
          BEAT_LEN: out_data.tx_byte <= ACK_LEN_BYTE;
          BEAT_FCF: out_data.tx_byte <= ACK_FCF_BYTE;
          BEAT_SEQ: out_data.tx_byte <= pend.seq;
          default:  out_data.tx_byte <= 8'd0;
        endcase
      end
    end
  end

endmodule
`default_nettype wire
